// ===== hw/rtl/signal_change_event_recorder_defines.svh =====
// Assertion macros shared by the recorder's checker.
`ifndef SIGNAL_CHANGE_EVENT_RECORDER_DEFINES_SVH
`define SIGNAL_CHANGE_EVENT_RECORDER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SCER_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("recorder check failed");

// Consequent checked in the cycle after the antecedent.
`define SCER_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("recorder check failed");

`endif

// ===== hw/rtl/scer_pkg.sv =====
// Types and constants of the signal change event recorder.
`timescale 1ns / 1ps

package scer_pkg;

  localparam int NUM_SIGNALS = 32;
  localparam int EVENT_DEPTH = 64;
  localparam int TICK_WIDTH  = 32;

  localparam int VAL_W  = 32;                       // width of a value vector
  localparam int SIG_W  = 5;                        // signal index width
  localparam int IDX_W  = 6;                        // read_index width
  localparam int OTICK_W = 32;                      // event_tick width
  localparam int ADDR_W = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int CNT_W  = 7;                        // events_stored / events_taken width

  typedef enum logic [2:0] {
    ACT_SCAN  = 3'd0,
    ACT_POP   = 3'd1,
    ACT_READ  = 3'd2,
    ACT_CLEAR = 3'd3,
    ACT_START = 3'd4,
    ACT_STOP  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [VAL_W-1:0] current_values;
    logic [VAL_W-1:0] previous_values;
    logic [31:0]      change_tick;
    logic [IDX_W-1:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic               event_valid;
    logic [SIG_W-1:0]   event_signal;
    logic [OTICK_W-1:0] event_tick;
    logic               event_value;
    logic [CNT_W-1:0]   events_stored;
    logic [CNT_W-1:0]   events_taken;
    logic               overflow;
    logic               running;
  } out_word_t;

  typedef struct packed {
    logic [SIG_W-1:0]      signal;
    logic [TICK_WIDTH-1:0] tick;
    logic                  value;
  } entry_t;

endpackage

// ===== hw/rtl/signal_change_event_recorder.sv =====
// Top level of the signal change event recorder.
`timescale 1ns / 1ps

// Signal change event recorder. Give a word on in_data with start high; it is
// taken when busy is low. Every word, of any action, returns exactly one status
// word on out_data, marked by out_strobe for a single cycle; the receiver
// cannot stall it, so it must capture out_data whenever out_strobe is high.
// The strobe cycle is also the first idle cycle, so the next word may be taken
// at the end of it. Pop, read-at, clear, start, stop, unused codes and a scan
// while stopped pass through EXEC and then FINISH, which registers the status
// word and the strobe. A scan while recording passes through EXEC, SCAN and
// FINISH, and in SCAN walks the signals one per cycle through the single write
// port of the event memory; it stops early when the store fills, at the first
// change that does not fit. Pops and reads go through the memory's registered
// read port: the read is issued in EXEC and its data is used in FINISH. The
// event memory needs no clearing: only slots below the stored count are ever
// read, and those were written since the last clear.
module signal_change_event_recorder
  import scer_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_data,
  output logic      out_strobe,
  output out_word_t out_data
);

  // control state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] wc_r, wc_nxt;     // events stored
  logic [CNT_W-1:0] rc_r, rc_nxt;     // events popped
  logic             run_r, run_nxt;   // recording enabled
  logic             strobe_r;

  // working registers
  in_word_t         item_r;
  logic [SIG_W-1:0] bit_r, bit_nxt;   // signal under scan
  logic             ovf_r, ovf_nxt;
  logic             ev_valid_r, ev_valid_nxt;
  out_word_t        out_r, out_nxt;

  // event memory, one write and one registered read port
  entry_t           mem [EVENT_DEPTH];
  entry_t           rd_data_r;
  entry_t           wr_entry;
  logic             mem_we;
  logic             mem_re;
  logic [ADDR_W-1:0] rd_addr;
  logic             finish;

  // scan decode
  logic [VAL_W-1:0] diff;
  logic             changed;
  logic             full;
  logic             last_bit;
  logic             do_fetch;

  assign diff     = item_r.current_values ^ item_r.previous_values;
  assign changed  = diff[bit_r];
  assign full     = (wc_r >= CNT_W'(EVENT_DEPTH));
  assign last_bit = (bit_r == SIG_W'(NUM_SIGNALS - 1));

  // pop or read-at that hits a stored slot
  always_comb begin
    do_fetch = 1'b0;
    unique case (item_r.action)
      ACT_POP:  do_fetch = (rc_r < wc_r);
      ACT_READ: do_fetch = (CNT_W'(item_r.read_index) < wc_r);
      default:  do_fetch = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if ((item_r.action == ACT_SCAN) && run_r) state_nxt = ST_SCAN;
        else state_nxt = ST_FINISH;
      end
      ST_SCAN: begin
        if ((changed && full) || last_bit) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs: handshake and memory strobes
  always_comb begin
    busy    = 1'b1;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    finish  = 1'b0;
    rd_addr = rc_r[ADDR_W-1:0];
    unique case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_EXEC: begin
        mem_re = do_fetch;
        if (item_r.action == ACT_READ) rd_addr = item_r.read_index[ADDR_W-1:0];
      end
      ST_SCAN:   mem_we = changed && !full;
      ST_FINISH: finish = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  assign wr_entry.signal = bit_r;
  assign wr_entry.tick   = item_r.change_tick[TICK_WIDTH-1:0];
  assign wr_entry.value  = item_r.current_values[bit_r];

  // datapath next values
  always_comb begin
    wc_nxt       = wc_r;
    rc_nxt       = rc_r;
    run_nxt      = run_r;
    bit_nxt      = bit_r;
    ovf_nxt      = ovf_r;
    ev_valid_nxt = ev_valid_r;
    out_nxt      = out_r;

    if (state_r == ST_EXEC) begin
      bit_nxt      = '0;
      ovf_nxt      = 1'b0;
      ev_valid_nxt = do_fetch;
      unique case (item_r.action)
        ACT_POP:   if (do_fetch) rc_nxt = rc_r + 1'b1;
        ACT_CLEAR: begin
          wc_nxt  = '0;
          rc_nxt  = '0;
          run_nxt = 1'b0;
        end
        ACT_START: run_nxt = 1'b1;
        ACT_STOP:  run_nxt = 1'b0;
        default:   run_nxt = run_r;
      endcase
    end

    if (state_r == ST_SCAN) begin
      if (mem_we) wc_nxt = wc_r + 1'b1;
      if (changed && full) ovf_nxt = 1'b1;
      if (!last_bit) bit_nxt = bit_r + 1'b1;
    end

    if (finish) begin
      out_nxt.event_valid   = ev_valid_r;
      out_nxt.event_signal  = ev_valid_r ? rd_data_r.signal : '0;
      out_nxt.event_tick    = ev_valid_r ? OTICK_W'(rd_data_r.tick) : '0;
      out_nxt.event_value   = ev_valid_r & rd_data_r.value;
      out_nxt.events_stored = wc_r;
      out_nxt.events_taken  = rc_r;
      out_nxt.overflow      = ovf_r;
      out_nxt.running       = run_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wc_r     <= '0;
      rc_r     <= '0;
      run_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wc_r     <= wc_nxt;
      rc_r     <= rc_nxt;
      run_r    <= run_nxt;
      strobe_r <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && start) item_r <= in_data;
    bit_r      <= bit_nxt;
    ovf_r      <= ovf_nxt;
    ev_valid_r <= ev_valid_nxt;
    out_r      <= out_nxt;
  end

  // Reads happen only in EXEC and writes only in SCAN, so the same slot is
  // never read and written in one cycle; no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (mem_we) mem[wc_r[ADDR_W-1:0]] <= wr_entry;
    if (mem_re) rd_data_r <= mem[rd_addr];
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

// ===== hw/rtl/scer_checker.sv =====
// Port-level checker for the signal change event recorder, with its bind.
`timescale 1ns / 1ps
`include "signal_change_event_recorder_defines.svh"

module scer_checker
  import scer_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_word_t out_data
);

  // event fields all zero
  logic ev_fields_zero;

  assign ev_fields_zero = (out_data.event_signal == '0) && (out_data.event_tick == '0) &&
                          (out_data.event_value == 1'b0);

  `SCER_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SCER_ASSERT_NOW(a_strobe_idle, out_strobe, !busy)
  `SCER_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe)
  `SCER_ASSERT_NOW(a_counts_order, out_strobe, out_data.events_taken <= out_data.events_stored)
  `SCER_ASSERT_NOW(a_empty_event, out_strobe && !out_data.event_valid, ev_fields_zero)

endmodule

bind signal_change_event_recorder scer_checker u_scer_checker (.*);
